[design/csm_pkg.sv]
`default_nettype none

package csm_pkg;

    localparam int CMD_W   = 2;
    localparam int COL_W   = 12;
    localparam int VAL_W   = 32;
    localparam int ROW_W   = 16;
    localparam int SUM_W   = 64;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [COL_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [ROW_W-1:0]        row_number;
        logic signed [SUM_W-1:0] row_sum;
        logic                    saturated;
    } t_out;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_END
    } t_kind;

    // classified transaction passed from front to back
    typedef struct packed {
        t_kind                   kind;
        logic                    hit;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_op;

endpackage

`default_nettype wire

[design/csm_ram.sv]
`default_nettype none

module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[design/csm_front.sv]
`default_nettype none

module csm_front #(
    parameter int VEC_LEN = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  csm_pkg::t_in i_in_data,
    output logic         o_in_stall,
    output logic         o_q_valid,
    output csm_pkg::t_op o_q_op,
    input  logic         i_q_pop
);

    import csm_pkg::*;

    localparam int QDepth = 4;
    localparam int QAW    = $clog2(QDepth);
    localparam logic [ROW_W:0]   VecLim = (ROW_W+1)'(VEC_LEN);
    localparam logic [QAW:0]     QFull  = (QAW+1)'(QDepth);

    t_op            r_q [QDepth];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    t_op            op;
    logic           keep;
    logic           push;

    always_comb begin
        op.col   = i_in_data.col_index;
        op.value = i_in_data.value;
        op.hit   = ({{(ROW_W+1-COL_W){1'b0}}, i_in_data.col_index} < VecLim);
        op.kind  = OP_END;
        keep     = 1'b0;
        case (i_in_data.cmd)
            CMD_LOAD: begin
                op.kind = OP_LOAD;
                keep    = op.hit;
            end
            CMD_MAC: begin
                op.kind = OP_MAC;
                keep    = 1'b1;
            end
            CMD_END: begin
                op.kind = OP_END;
                keep    = 1'b1;
            end
            default: begin
                keep    = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_count == QFull);
    assign push       = i_in_valid && !o_in_stall && keep;
    assign o_q_valid  = (r_count != '0);
    assign o_q_op     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= op;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop && r_count != QFull) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QFull) else $error("queue overfilled");

endmodule

`default_nettype wire

[design/csm_back.sv]
`default_nettype none

module csm_back #(
    parameter int MAX_ROWS = 65536,
    parameter int ADDR_W   = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  csm_pkg::t_op              i_q_op,
    output logic                      o_q_pop,
    output logic                      o_ram_wr_en,
    output logic                      o_ram_rd_en,
    output logic [ADDR_W-1:0]         o_ram_addr,
    output logic [csm_pkg::VAL_W-1:0] o_ram_wr_data,
    input  logic [csm_pkg::VAL_W-1:0] i_ram_rd_data,
    output logic                      o_out_valid,
    output csm_pkg::t_out             o_out_data,
    input  logic                      i_out_stall
);

    import csm_pkg::*;

    localparam logic [ROW_W:0] RowLim = (ROW_W+1)'(MAX_ROWS);

    logic                     r_s1_valid;
    t_kind                    r_s1_kind;
    logic                     r_s1_hit;
    logic signed [VAL_W-1:0]  r_s1_value;

    logic                     r_s2_valid;
    t_kind                    r_s2_kind;
    logic signed [SUM_W-1:0]  r_s2_prod;

    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_sat;
    logic [ROW_W-1:0]         r_row;
    logic                     r_out_valid;
    t_out                     r_out;

    logic                     en;
    logic                     s2_end;
    logic signed [SUM_W-1:0]  mul;
    logic signed [SUM_W-1:0]  prod;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
    logic signed [SUM_W-1:0]  n_acc;
    logic [ROW_W:0]           row_inc;
    logic [ROW_W-1:0]         n_row;

    assign s2_end  = r_s2_valid && (r_s2_kind == OP_END);
    assign en      = !(s2_end && r_out_valid && i_out_stall);
    assign o_q_pop = i_q_valid && en;

    assign o_ram_addr    = i_q_op.col[ADDR_W-1:0];
    assign o_ram_wr_data = i_q_op.value;
    assign o_ram_wr_en   = o_q_pop && (i_q_op.kind == OP_LOAD);
    assign o_ram_rd_en   = o_q_pop && (i_q_op.kind == OP_MAC);

    // signed 32 x 32 product, exact in Q32.32
    assign mul  = SUM_W'(r_s1_value) * SUM_W'($signed(i_ram_rd_data));
    assign prod = r_s1_hit ? mul : '0;

    assign sum   = r_acc + r_s2_prod;
    assign ovf   = (r_acc[SUM_W-1] == r_s2_prod[SUM_W-1]) && (sum[SUM_W-1] != r_acc[SUM_W-1]);
    assign n_acc = ovf ? (r_s2_prod[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;

    assign row_inc = {1'b0, r_row} + 1'b1;
    assign n_row   = (row_inc >= RowLim) ? '0 : row_inc[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind  <= i_q_op.kind;
            r_s1_hit   <= i_q_op.hit;
            r_s1_value <= i_q_op.value;
            r_s2_kind  <= r_s1_kind;
            r_s2_prod  <= prod;
        end
        if (en && s2_end) begin
            r_out.row_number <= r_row;
            r_out.row_sum    <= r_acc;
            r_out.saturated  <= r_sat;
        end
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_s1_valid <= o_q_pop && (i_q_op.kind != OP_LOAD);
                r_s2_valid <= r_s1_valid;
                if (r_s2_valid) begin
                    case (r_s2_kind)
                        OP_MAC: begin
                            r_acc <= n_acc;
                            r_sat <= r_sat | ovf;
                        end
                        OP_END: begin
                            r_acc <= '0;
                            r_sat <= 1'b0;
                            r_row <= n_row;
                        end
                        default: begin
                            r_acc <= r_acc;
                        end
                    endcase
                end
            end
            if (en && s2_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s1_valid) && $stable(r_s2_valid))
        else $error("pipeline moved while blocked");

    a_row_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && s2_end) |=> o_out_valid && (o_out_data.row_sum == $past(r_acc))
            && (o_out_data.row_number == $past(r_row)))
        else $error("end of row not emitted");

    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && s2_end) |=> (r_acc == '0) && !r_sat)
        else $error("row sum not cleared");

endmodule

`default_nettype wire

[design/csr_sparse_matvec.sv]
`default_nettype none

// channel   dir  handshake                   payload
// in        in   i_in_valid / o_in_stall     i_in_data  (cmd, col_index, value)
// out       out  o_out_valid / i_out_stall   o_out_data (row_number, row_sum, saturated)
//
// While o_in_stall is low, one transaction per cycle is taken: load, nonzero or end of row.
// The single multiply-accumulate path takes one nonzero per cycle while the back end runs.
// An end of row passes stage 1 and stage 2, then its row result is registered for output.
// Reset clears the queue, pipeline, row sum, flag and row counter; no clearing pass.
// The back end freezes only while a row result waits on a stalled output and another end
// of row is in stage 2; the four-entry queue then fills before o_in_stall rises.

module csr_sparse_matvec #(
    parameter int VEC_LEN  = 4096,
    parameter int MAX_ROWS = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  csm_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output csm_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    import csm_pkg::*;

    localparam int StoreDepth = (VEC_LEN < (1 << COL_W)) ? VEC_LEN : (1 << COL_W);
    localparam int StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

    logic               q_valid;
    t_op                q_op;
    logic               q_pop;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [StoreAw-1:0] ram_addr;
    logic [VAL_W-1:0]   ram_wr_data;
    logic [VAL_W-1:0]   ram_rd_data;

    csm_front #(
        .VEC_LEN (VEC_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_q_valid  (q_valid),
        .o_q_op     (q_op),
        .i_q_pop    (q_pop)
    );

    csm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (StoreDepth),
        .AW    (StoreAw)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd_data)
    );

    csm_back #(
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (StoreAw)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .o_q_pop       (q_pop),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_addr    (ram_addr),
        .o_ram_wr_data (ram_wr_data),
        .i_ram_rd_data (ram_rd_data),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

`default_nettype wire
